// ===== rtl/core/slx_pkg.sv =====
// ----------------------------------------------------------------------------
// slx_pkg
// Shared types and constants of the s-expression token lexer.
// ----------------------------------------------------------------------------
package slx_pkg;

  // most results that one text byte can cause
  localparam int unsigned SLX_MAX_RES   = 4;
  localparam int unsigned SLX_IDX_W     = $clog2(SLX_MAX_RES);
  localparam int unsigned SLX_CNT_W     = $clog2(SLX_MAX_RES + 1);
  // default depth of the command queue between front and back
  localparam int unsigned SLX_CMD_DEPTH = 4;

  typedef enum logic [2:0] {
    KIND_TEXT   = 3'd0,
    KIND_INT    = 3'd1,
    KIND_DOUBLE = 3'd2,
    KIND_STRING = 3'd3,
    KIND_DATE   = 3'd4,
    KIND_IDENT  = 3'd5,
    KIND_SINGLE = 3'd6,
    KIND_EOT    = 3'd7
  } kind_t;

  // everything one text byte produces, handed from front to back
  typedef struct packed {
    logic  [SLX_MAX_RES-1:0][7:0] bytes;
    kind_t [SLX_MAX_RES-1:0]      kinds;
    logic  [SLX_CNT_W-1:0]        count;
    logic  [15:0]                 line;
  } cmd_t;

endpackage

// ===== rtl/core/slx_front.sv =====
// ----------------------------------------------------------------------------
// slx_front
// Accepts text bytes, runs the lexer mode machine and builds one command of
// up to four results for every byte.
// ----------------------------------------------------------------------------
module slx_front
  import slx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_text_byte,
  output logic       in_full,
  input  logic       q_full,
  output logic       q_wr,
  output cmd_t       q_wdata
);

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_COMMENT = 3'd1,
    M_QMARK   = 3'd2,
    M_MINUS   = 3'd3,
    M_NUMBER  = 3'd4,
    M_IDENT   = 3'd5,
    M_STRING  = 3'd6,
    M_ESC     = 3'd7
  } mode_t;

  localparam logic [1:0] NK_INT    = 2'd0;
  localparam logic [1:0] NK_DOUBLE = 2'd1;
  localparam logic [1:0] NK_DATE   = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  nk_r, nk_nxt;
  logic [15:0] line_r, line_nxt;
  cmd_t        cmd;
  logic        idle_run;
  logic        line_inc;
  logic [11:0] dig;
  logic [8:0]  esc;
  logic [7:0]  c;
  logic        accept;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  // _ - + * / % < > = &
  function automatic logic is_punct(input logic [7:0] b);
    return b inside {8'h5F, 8'h2D, 8'h2B, 8'h2A, 8'h2F, 8'h25, 8'h3C, 8'h3E,
                     8'h3D, 8'h26};
  endfunction

  function automatic logic ident_more(input logic [7:0] b);
    return is_digit(b) || is_alpha(b) || is_punct(b);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b inside {8'h20, 8'h0C, 8'h09, 8'h0B, 8'h0D};
  endfunction

  // {hit, control byte}
  function automatic logic [8:0] escape_code(input logic [7:0] b);
    logic [8:0] r;
    case (b)
      8'h61:   r = {1'b1, 8'h07};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      8'h76:   r = {1'b1, 8'h0B};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // binary to three bcd digits, shift-and-add-3
  function automatic logic [11:0] to_bcd(input logic [7:0] b);
    logic [19:0] s;
    s = {12'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (s[11:8] >= 4'd5) s[11:8] = s[11:8] + 4'd3;
      if (s[15:12] >= 4'd5) s[15:12] = s[15:12] + 4'd3;
      if (s[19:16] >= 4'd5) s[19:16] = s[19:16] + 4'd3;
      s = s << 1;
    end
    return s[19:8];
  endfunction

  function automatic cmd_t put(input cmd_t cin, input logic [7:0] b, input kind_t k);
    cmd_t co;
    co = cin;
    co.bytes[cin.count[SLX_IDX_W-1:0]] = b;
    co.kinds[cin.count[SLX_IDX_W-1:0]] = k;
    co.count = cin.count + SLX_CNT_W'(1);
    return co;
  endfunction

  assign c      = in_text_byte;
  assign dig    = to_bcd(c);
  assign esc    = escape_code(c);
  assign accept = in_push && !q_full;

  always_comb begin
    mode_nxt = mode_r;
    nk_nxt   = nk_r;
    cmd      = '0;
    idle_run = 1'b0;
    line_inc = 1'b0;
    case (mode_r)
      M_COMMENT: begin
        if (c == CH_LF) begin
          line_inc = 1'b1;
          mode_nxt = M_IDLE;
        end else if (c == CH_NUL) begin
          mode_nxt = M_IDLE;
          cmd      = put(cmd, CH_NUL, KIND_EOT);
        end
      end
      M_QMARK: begin
        if (c >= 8'd100) cmd = put(cmd, CH_ZERO | {4'd0, dig[11:8]}, KIND_TEXT);
        if (c >= 8'd10) cmd = put(cmd, CH_ZERO | {4'd0, dig[7:4]}, KIND_TEXT);
        cmd      = put(cmd, CH_ZERO | {4'd0, dig[3:0]}, KIND_TEXT);
        cmd      = put(cmd, CH_NUL, KIND_INT);
        mode_nxt = M_IDLE;
        if (c == CH_NUL) cmd = put(cmd, CH_NUL, KIND_EOT);
      end
      M_MINUS: begin
        cmd = put(cmd, CH_MINUS, KIND_TEXT);
        if (is_digit(c)) begin
          cmd      = put(cmd, c, KIND_TEXT);
          nk_nxt   = NK_INT;
          mode_nxt = M_NUMBER;
        end else if (ident_more(c)) begin
          cmd      = put(cmd, c, KIND_TEXT);
          mode_nxt = M_IDENT;
        end else begin
          cmd      = put(cmd, CH_NUL, KIND_IDENT);
          mode_nxt = M_IDLE;
          idle_run = 1'b1;
        end
      end
      M_NUMBER: begin
        if (is_digit(c) || c == CH_DOT || c == CH_MINUS) begin
          if (c == CH_DOT) nk_nxt = NK_DOUBLE;
          else if (c == CH_MINUS) nk_nxt = NK_DATE;
          cmd = put(cmd, c, KIND_TEXT);
        end else begin
          if (nk_r == NK_DOUBLE) cmd = put(cmd, CH_NUL, KIND_DOUBLE);
          else if (nk_r == NK_DATE) cmd = put(cmd, CH_NUL, KIND_DATE);
          else cmd = put(cmd, CH_NUL, KIND_INT);
          nk_nxt   = NK_INT;
          mode_nxt = M_IDLE;
          idle_run = 1'b1;
        end
      end
      M_IDENT: begin
        if (ident_more(c)) begin
          cmd = put(cmd, c, KIND_TEXT);
        end else begin
          cmd      = put(cmd, CH_NUL, KIND_IDENT);
          mode_nxt = M_IDLE;
          idle_run = 1'b1;
        end
      end
      M_STRING: begin
        if (c == CH_DQ) begin
          cmd      = put(cmd, CH_NUL, KIND_STRING);
          mode_nxt = M_IDLE;
        end else if (c == CH_NUL) begin
          cmd      = put(cmd, CH_NUL, KIND_STRING);
          cmd      = put(cmd, CH_NUL, KIND_EOT);
          mode_nxt = M_IDLE;
        end else if (c == CH_BSL) begin
          mode_nxt = M_ESC;
        end else begin
          if (c == CH_LF) line_inc = 1'b1;
          cmd = put(cmd, c, KIND_TEXT);
        end
      end
      M_ESC: begin
        mode_nxt = M_STRING;
        if (c == CH_NUL) begin
          cmd      = put(cmd, CH_BSL, KIND_TEXT);
          cmd      = put(cmd, CH_NUL, KIND_STRING);
          cmd      = put(cmd, CH_NUL, KIND_EOT);
          mode_nxt = M_IDLE;
        end else if (c == CH_LF) begin
          // line continuation inside a string
          line_inc = 1'b1;
        end else if (esc[8]) begin
          cmd = put(cmd, esc[7:0], KIND_TEXT);
        end else begin
          cmd = put(cmd, CH_BSL, KIND_TEXT);
          cmd = put(cmd, c, KIND_TEXT);
        end
      end
      default: idle_run = 1'b1;
    endcase

    // between-token handling, also for the byte that just ended a token
    if (idle_run) begin
      if (c == CH_NUL) begin
        cmd = put(cmd, CH_NUL, KIND_EOT);
      end else if (c == CH_LF) begin
        line_inc = 1'b1;
      end else if (is_blank(c)) begin
        mode_nxt = M_IDLE;
      end else if (c == CH_SEMI) begin
        mode_nxt = M_COMMENT;
      end else if (c == CH_QM) begin
        mode_nxt = M_QMARK;
      end else if (c == CH_MINUS) begin
        mode_nxt = M_MINUS;
      end else if (is_digit(c)) begin
        cmd      = put(cmd, c, KIND_TEXT);
        nk_nxt   = NK_INT;
        mode_nxt = M_NUMBER;
      end else if (is_alpha(c) || is_punct(c)) begin
        cmd      = put(cmd, c, KIND_TEXT);
        mode_nxt = M_IDENT;
      end else if (c == CH_DQ) begin
        mode_nxt = M_STRING;
      end else begin
        cmd = put(cmd, c, KIND_SINGLE);
      end
    end

    line_nxt = (line_inc && line_r != 16'hFFFF) ? line_r + 16'd1 : line_r;
    cmd.line = line_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      nk_r   <= NK_INT;
      line_r <= 16'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      nk_r   <= nk_nxt;
      line_r <= line_nxt;
    end
  end

  assign in_full = q_full;
  assign q_wr    = accept && (cmd.count != '0);
  assign q_wdata = cmd;

endmodule

// ===== rtl/core/slx_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// slx_cmd_queue
// Small command queue between the lexer front and the result serializer.
// ----------------------------------------------------------------------------
module slx_cmd_queue
  import slx_pkg::*;
#(
  parameter int unsigned DEPTH = SLX_CMD_DEPTH
)(
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  cmd_t wdata,
  output logic full,
  input  logic rd,
  output cmd_t rdata,
  output logic empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= bump(wr_ptr_r);
      if (do_rd) rd_ptr_r <= bump(rd_ptr_r);
      if (do_wr && !do_rd) cnt_r <= cnt_r + CNT_W'(1);
      else if (do_rd && !do_wr) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("command queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr && full))
    else $error("command written into a full queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (empty || full) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/core/slx_back.sv =====
// ----------------------------------------------------------------------------
// slx_back
// Takes commands from the queue and sends their results out one per cycle,
// while the output is popped, through an output register.
// ----------------------------------------------------------------------------
module slx_back
  import slx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  cmd_t        q_rdata,
  output logic        q_rd,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_byte,
  output logic [2:0]  out_token_kind,
  output logic [15:0] out_line_count,
  output logic        out_last_of_run
);

  cmd_t                 cur_r;
  logic                 cur_vld_r;
  logic [SLX_IDX_W-1:0] idx_r;
  logic                 out_vld_r;
  logic [7:0]           byte_r;
  kind_t                kind_r;
  logic [15:0]          line_r;
  logic                 last_r;
  logic                 adv;
  logic                 last;

  assign adv  = cur_vld_r && (!out_vld_r || out_pop);
  assign last = ({1'b0, idx_r} + SLX_CNT_W'(1)) == cur_r.count;
  // refill the command register when it is free or its last beat leaves
  assign q_rd = !cur_vld_r || (adv && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv) out_vld_r <= 1'b1;
      else if (out_pop) out_vld_r <= 1'b0;

      if (q_rd) begin
        cur_vld_r <= !q_empty;
        idx_r     <= '0;
      end else if (adv) begin
        idx_r <= idx_r + SLX_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd && !q_empty) cur_r <= q_rdata;
    if (adv) begin
      byte_r <= cur_r.bytes[idx_r];
      kind_r <= cur_r.kinds[idx_r];
      line_r <= cur_r.line;
      last_r <= last;
    end
  end

  assign out_empty       = !out_vld_r;
  assign out_byte        = byte_r;
  assign out_token_kind  = kind_r;
  assign out_line_count  = line_r;
  assign out_last_of_run = last_r;

endmodule

// ===== rtl/core/sexpr_token_lexer.sv =====
// ----------------------------------------------------------------------------
// sexpr_token_lexer
// Streaming lexer for Lisp-style text, one byte in, a run of token results out.
// ----------------------------------------------------------------------------
// One text byte is taken every cycle while the command queue has room. Each
// byte causes zero to four results (token text bytes, end markers, single
// characters, end of text), and results leave one per cycle while the output
// is popped, so the sustained rate is one byte per cycle as long as bytes
// average one result or fewer. A byte's results pass through the command
// queue, the command register and the output register. A queue of CMD_DEPTH
// commands lets the front keep lexing while the output side stalls.
module sexpr_token_lexer
  import slx_pkg::*;
#(
  parameter int unsigned CMD_DEPTH = SLX_CMD_DEPTH
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_text_byte,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_byte,
  output logic [2:0]  out_token_kind,
  output logic [15:0] out_line_count,
  output logic        out_last_of_run
);

  logic q_full, q_wr, q_rd, q_empty;
  cmd_t q_wdata, q_rdata;

  slx_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_text_byte (in_text_byte),
    .in_full      (in_full),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .q_wdata      (q_wdata)
  );

  slx_cmd_queue #(
    .DEPTH (CMD_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  slx_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_rdata         (q_rdata),
    .q_rd            (q_rd),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_byte        (out_byte),
    .out_token_kind  (out_token_kind),
    .out_line_count  (out_line_count),
    .out_last_of_run (out_last_of_run)
  );

endmodule
